[design/acl_pkg.sv]
// shared types, codes and helper functions for the cidr access list filter
`default_nettype none
package acl_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_WIDTH = 32;

  // field widths
  localparam int OP_W    = 3;
  localparam int ADDR_W  = 32;
  localparam int PLEN_W  = 6;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;
  localparam int KIND_W  = 2;

  // operations
  localparam logic [OP_W-1:0] OP_CHECK     = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_ALLOW = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_BLOCK = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_ALLOW = 3'd3;
  localparam logic [OP_W-1:0] OP_REM_BLOCK = 3'd4;

  // modes
  localparam logic [MODE_W-1:0] MODE_NONE       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOOPBACK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PRIVATE    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ALLOW_LIST = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BLOCK_LIST = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DENY       = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // scan kinds
  localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  // well-known leading octets
  localparam logic [7:0] OCT_LOOPBACK = 8'd127;
  localparam logic [7:0] OCT_TEN      = 8'd10;
  localparam logic [7:0] OCT_192      = 8'd192;
  localparam logic [7:0] OCT_168      = 8'd168;
  localparam logic [7:0] OCT_172      = 8'd172;
  localparam logic [7:0] OCT_16       = 8'd16;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [PLEN_W-1:0] mask_len;
  } in_item_t;

  typedef struct packed {
    logic                   allowed;
    logic [STAT_W-1:0]      status;
    logic [COUNT_WIDTH-1:0] total_count;
    logic [COUNT_WIDTH-1:0] allowed_count;
    logic [COUNT_WIDTH-1:0] blocked_count;
  } out_item_t;

  typedef struct packed {
    logic              active;
    logic              is_allow;
    logic [PLEN_W-1:0] prefix;
    logic [ADDR_W-1:0] address;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              want_allow;
    logic [PLEN_W-1:0] prefix;
    logic [ADDR_W-1:0] address;
  } scan_job_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_res_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  // leading plen bits equal; zero matches all, 32 and above is exact
  function automatic logic prefix_match(input logic [ADDR_W-1:0] a,
                                        input logic [ADDR_W-1:0] b,
                                        input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] mask;
    mask = ~({ADDR_W{1'b1}} >> plen);
    return ((a & mask) == (b & mask));
  endfunction

  // verdict for modes that need no table
  function automatic logic fixed_verdict(input logic [MODE_W-1:0] mode,
                                         input logic [ADDR_W-1:0] a);
    logic [7:0] o1;
    logic [7:0] o2;
    logic       v;
    o1 = a[31:24];
    o2 = a[23:16];
    case (mode)
      MODE_LOOPBACK: v = (o1 == OCT_LOOPBACK);
      MODE_PRIVATE:  v = ((o1 == OCT_192) && (o2 == OCT_168)) || (o1 == OCT_TEN) ||
                         ((o1 == OCT_172) && (o2 == OCT_16));
      MODE_DENY:     v = 1'b0;
      default:       v = 1'b1;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[design/acl_ram.sv]
// entry table memory, one write and one registered read port
`default_nettype none
module acl_ram (
  input  wire                      clk,
  input  wire acl_pkg::ram_rd_t    rd_i,
  input  wire acl_pkg::ram_wr_t    wr_i,
  output acl_pkg::entry_t          rd_data_o
);

  acl_pkg::entry_t mem_r [acl_pkg::TABLE_DEPTH];
  acl_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      mem_r[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_i.en) begin
      rd_data_r <= mem_r[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_r;

endmodule
`default_nettype wire

[design/acl_scan.sv]
// table walker: lookup, free-slot search and remove over the entry memory
`default_nettype none
module acl_scan (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start_i,
  input  wire acl_pkg::scan_job_t    job_i,
  output acl_pkg::scan_res_t         res_o,
  output acl_pkg::ram_rd_t           rd_o,
  output acl_pkg::ram_wr_t           wr_o,
  input  wire acl_pkg::entry_t       rd_data_i
);

  acl_pkg::scan_job_t              job_r;
  logic                            busy_r, busy_nxt;
  logic                            pend_r, pend_nxt;
  logic [acl_pkg::IDX_W-1:0]       pend_idx_r, pend_idx_nxt;
  logic [acl_pkg::FILL_W-1:0]      rd_idx_r, rd_idx_nxt;
  // slots at and above the fill mark were never written and count as free
  logic [acl_pkg::FILL_W-1:0]      fill_r, fill_nxt;

  logic kind_match, match, hit, exhausted, issue, tail_ok;

  always_comb begin
    kind_match = rd_data_i.active && (rd_data_i.is_allow == job_r.want_allow);
    case (job_r.kind)
      acl_pkg::KIND_CHECK:
        match = kind_match &&
                acl_pkg::prefix_match(job_r.address, rd_data_i.address, rd_data_i.prefix);
      acl_pkg::KIND_ADD:    match = !rd_data_i.active;
      acl_pkg::KIND_REMOVE: match = kind_match && (rd_data_i.address == job_r.address);
      default:              match = 1'b0;
    endcase
    hit       = busy_r && pend_r && match;
    exhausted = busy_r && !pend_r && (rd_idx_r >= fill_r);
    issue     = busy_r && !hit && !exhausted && (rd_idx_r < fill_r);
    tail_ok   = (fill_r < acl_pkg::FILL_W'(acl_pkg::TABLE_DEPTH));

    rd_o.en   = issue;
    rd_o.addr = rd_idx_r[acl_pkg::IDX_W-1:0];

    wr_o.en               = 1'b0;
    wr_o.addr             = pend_idx_r;
    wr_o.data.active      = 1'b1;
    wr_o.data.is_allow    = job_r.want_allow;
    wr_o.data.prefix      = job_r.prefix;
    wr_o.data.address     = job_r.address;
    fill_nxt              = fill_r;
    if (hit && (job_r.kind == acl_pkg::KIND_ADD)) begin
      wr_o.en = 1'b1;
    end else if (hit && (job_r.kind == acl_pkg::KIND_REMOVE)) begin
      wr_o.en          = 1'b1;
      wr_o.data        = rd_data_i;
      wr_o.data.active = 1'b0;
    end else if (exhausted && (job_r.kind == acl_pkg::KIND_ADD) && tail_ok) begin
      wr_o.en   = 1'b1;
      wr_o.addr = fill_r[acl_pkg::IDX_W-1:0];
      fill_nxt  = fill_r + 1'b1;
    end

    res_o.done  = hit || exhausted;
    res_o.found = hit || (exhausted && (job_r.kind == acl_pkg::KIND_ADD) && tail_ok);

    busy_nxt     = start_i ? 1'b1 : (res_o.done ? 1'b0 : busy_r);
    rd_idx_nxt   = start_i ? '0 : (issue ? rd_idx_r + 1'b1 : rd_idx_r);
    pend_nxt     = issue;
    pend_idx_nxt = issue ? rd_idx_r[acl_pkg::IDX_W-1:0] : pend_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      fill_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (start_i) begin
      job_r <= job_i;
    end
  end

endmodule
`default_nettype wire

[design/cidr_access_list_filter_top.sv]
// top level of the cidr access list filter: handshakes, mode, counters, result
//
//  channel  | direction | signals                      | beat
//  ---------+-----------+------------------------------+-----------------------------
//  in       | input     | in_valid, in_ready, in_data  | operation, address, prefix
//  out      | output    | out_valid, out_ready,out_data| verdict, status, counters
//  cfg      | input     | cfg_we, cfg_wdata            | mode, written when cfg_we high
//
// one beat at a time; a fixed-mode check or unused operation goes through the fixed state
// table work walks the slots below the fill mark, one memory read per slot;
//   a hit ends the walk early
// synchronous active-low reset clears mode, counters and the fill mark, no clearing pass
// a held result does not block the next input beat; that beat's result waits for out_ready
`default_nettype none
module cidr_access_list_filter_top (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire acl_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output acl_pkg::out_item_t                out_data,
  input  wire                               cfg_we,
  input  wire [acl_pkg::MODE_W-1:0]         cfg_wdata
);

  // control states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FIXED  = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic [acl_pkg::MODE_W-1:0]     mode_r;
  logic [acl_pkg::OP_W-1:0]       op_r;
  logic [acl_pkg::ADDR_W-1:0]     addr_r;
  logic [acl_pkg::COUNT_WIDTH-1:0] tot_r, tot_nxt, alw_r, alw_nxt, blk_r, blk_nxt;
  acl_pkg::out_item_t             res_r, res_nxt;
  acl_pkg::out_item_t             out_data_r;
  logic                           out_valid_r, out_valid_nxt;

  acl_pkg::scan_job_t   job;
  acl_pkg::scan_res_t   scan_res;
  acl_pkg::ram_rd_t     ram_rd;
  acl_pkg::ram_wr_t     ram_wr;
  acl_pkg::entry_t      ram_q;

  logic accept, need_scan, form_en, form_check, form_allowed, load_out;
  logic [acl_pkg::STAT_W-1:0] form_status;

  acl_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (accept && need_scan),
    .job_i     (job),
    .res_o     (scan_res),
    .rd_o      (ram_rd),
    .wr_o      (ram_wr),
    .rd_data_i (ram_q)
  );

  acl_ram u_ram (
    .clk       (clk),
    .rd_i      (ram_rd),
    .wr_i      (ram_wr),
    .rd_data_o (ram_q)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // decode the incoming beat into a table job
  always_comb begin
    job.prefix     = in_data.mask_len;
    job.address    = in_data.address;
    job.kind       = acl_pkg::KIND_CHECK;
    job.want_allow = 1'b0;
    need_scan      = 1'b0;
    case (in_data.operation)
      acl_pkg::OP_CHECK: begin
        job.want_allow = (mode_r == acl_pkg::MODE_ALLOW_LIST);
        need_scan      = (mode_r == acl_pkg::MODE_ALLOW_LIST) ||
                         (mode_r == acl_pkg::MODE_BLOCK_LIST);
      end
      acl_pkg::OP_ADD_ALLOW: begin
        job.kind = acl_pkg::KIND_ADD;    job.want_allow = 1'b1; need_scan = 1'b1;
      end
      acl_pkg::OP_ADD_BLOCK: begin
        job.kind = acl_pkg::KIND_ADD;    need_scan = 1'b1;
      end
      acl_pkg::OP_REM_ALLOW: begin
        job.kind = acl_pkg::KIND_REMOVE; job.want_allow = 1'b1; need_scan = 1'b1;
      end
      acl_pkg::OP_REM_BLOCK: begin
        job.kind = acl_pkg::KIND_REMOVE; need_scan = 1'b1;
      end
      default: need_scan = 1'b0;
    endcase
  end

  // form the result once the verdict or table status is known
  always_comb begin
    form_en      = 1'b0;
    form_check   = (op_r == acl_pkg::OP_CHECK);
    form_allowed = 1'b0;
    form_status  = acl_pkg::STATUS_OK;
    if (state_r == ST_FIXED) begin
      form_en      = 1'b1;
      form_allowed = form_check && acl_pkg::fixed_verdict(mode_r, addr_r);
    end else if (state_r == ST_SCAN) begin
      form_en = scan_res.done;
      case (op_r)
        acl_pkg::OP_CHECK:
          form_allowed = (mode_r == acl_pkg::MODE_ALLOW_LIST) ? scan_res.found
                                                              : !scan_res.found;
        acl_pkg::OP_ADD_ALLOW, acl_pkg::OP_ADD_BLOCK:
          form_status = scan_res.found ? acl_pkg::STATUS_OK : acl_pkg::STATUS_FULL;
        acl_pkg::OP_REM_ALLOW, acl_pkg::OP_REM_BLOCK:
          form_status = scan_res.found ? acl_pkg::STATUS_OK : acl_pkg::STATUS_NOT_FOUND;
        default: form_status = acl_pkg::STATUS_OK;
      endcase
    end

    // saturating counters
    tot_nxt = tot_r;
    alw_nxt = alw_r;
    blk_nxt = blk_r;
    if (form_en && form_check) begin
      tot_nxt = (&tot_r) ? tot_r : tot_r + 1'b1;
      if (form_allowed) begin
        alw_nxt = (&alw_r) ? alw_r : alw_r + 1'b1;
      end else begin
        blk_nxt = (&blk_r) ? blk_r : blk_r + 1'b1;
      end
    end

    res_nxt = res_r;
    if (form_en) begin
      res_nxt.allowed       = form_allowed;
      res_nxt.status        = form_status;
      res_nxt.total_count   = tot_nxt;
      res_nxt.allowed_count = alw_nxt;
      res_nxt.blocked_count = blk_nxt;
    end

    // output register takes the result as soon as it is free
    load_out      = (state_r == ST_RESULT) && (!out_valid_r || out_ready);
    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = need_scan ? ST_SCAN : ST_FIXED;
      ST_FIXED:  state_nxt = ST_RESULT;
      ST_SCAN:   if (form_en) state_nxt = ST_RESULT;
      ST_RESULT: if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= acl_pkg::MODE_NONE;
      tot_r       <= '0;
      alw_r       <= '0;
      blk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tot_r       <= tot_nxt;
      alw_r       <= alw_nxt;
      blk_r       <= blk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept) begin
      op_r   <= in_data.operation;
      addr_r <= in_data.address;
    end
    if (load_out) begin
      out_data_r <= res_r;
    end
  end

`ifndef SYNTH
  // the walker only reports while a table job is open
  assert property (@(posedge clk) disable iff (!rst_n)
    scan_res.done |-> (state_r == ST_SCAN))
    else $error("scan finished outside table job");

  // every check is counted in total, so neither split can pass it
  assert property (@(posedge clk) disable iff (!rst_n)
    (tot_r >= alw_r) && (tot_r >= blk_r))
    else $error("check counters out of step");

  // an accepted beat always starts work
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_FIXED) || (state_r == ST_SCAN))
    else $error("accepted beat not started");

  // a formed result reaches the output register before the next beat
  assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && (state_r == ST_IDLE))
    else $error("result not loaded");
`endif

endmodule
`default_nettype wire

[dv/tb_cidr_access_list_filter_top.sv]
`timescale 1ns / 1ps
// testbench for the cidr access list filter top level, checked beat by beat against a predictor
module tb_cidr_access_list_filter_top;

  // operation and mode codes that the package leaves unnamed
  localparam logic [acl_pkg::OP_W-1:0]   OP_SPARE_5   = 3'd5;
  localparam logic [acl_pkg::OP_W-1:0]   OP_SPARE_7   = 3'd7;
  localparam logic [acl_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [acl_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  localparam int IDLE_PCT    = 23;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 60;
  localparam int NUM_PHASES  = 9;

  localparam logic [acl_pkg::COUNT_WIDTH-1:0] COUNT_TOP = '1;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  acl_pkg::in_item_t           in_data   = '0;
  logic                        out_ready = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic [acl_pkg::MODE_W-1:0]  cfg_wdata = '0;
  logic                        in_ready;
  logic                        out_valid;
  acl_pkg::out_item_t          out_data;

  cidr_access_list_filter_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: a private copy of the entry table, the counters and mode
  // ---------------------------------------------------------------------------
  logic [acl_pkg::ADDR_W-1:0]    tbl_addr  [acl_pkg::TABLE_DEPTH];
  logic [acl_pkg::PLEN_W-1:0]    tbl_plen  [acl_pkg::TABLE_DEPTH];
  bit                            tbl_allow [acl_pkg::TABLE_DEPTH];
  bit                            tbl_used  [acl_pkg::TABLE_DEPTH];
  bit [acl_pkg::COUNT_WIDTH-1:0] chk_total;
  bit [acl_pkg::COUNT_WIDTH-1:0] chk_allowed;
  bit [acl_pkg::COUNT_WIDTH-1:0] chk_blocked;
  logic [acl_pkg::MODE_W-1:0]    acl_mode = acl_pkg::MODE_NONE;

  // expected results in arrival order, and beats waiting to be offered
  acl_pkg::out_item_t            acl_outcomes [$];
  acl_pkg::in_item_t             tx_queue [$];
  // addresses handed to add operations, so removes and checks can aim at them
  logic [acl_pkg::ADDR_W-1:0]    added_addrs [$];

  logic                   in_taken    = 1'b0;
  logic                   tx_steady   = 1'b0;
  logic                   rx_hold     = 1'b0;
  logic                   pressure_go = 1'b0;

  int                     err_count       = 0;
  int                     beats_sent      = 0;
  int                     results_checked = 0;
  int                     full_seen       = 0;
  int                     miss_seen       = 0;

  function automatic bit [acl_pkg::COUNT_WIDTH-1:0] sat_inc(
    bit [acl_pkg::COUNT_WIDTH-1:0] c);
    return (c == COUNT_TOP) ? c : c + 1'b1;
  endfunction

  // any active entry of the wanted kind whose prefix covers the address
  function automatic bit table_covers(logic [acl_pkg::ADDR_W-1:0] a, bit want_allow);
    logic [acl_pkg::ADDR_W-1:0] mask;
    bit                         hit;
    hit = 1'b0;
    for (int i = 0; i < acl_pkg::TABLE_DEPTH; i++) begin
      if (tbl_used[i] && tbl_allow[i] == want_allow) begin
        // zero prefix masks nothing, 32 and above compares every bit
        mask = (tbl_plen[i] >= 6'd32) ? '1 : ~({acl_pkg::ADDR_W{1'b1}} >> tbl_plen[i]);
        if ((a & mask) == (tbl_addr[i] & mask)) hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // update the private state for one accepted beat and return its result
  function automatic acl_pkg::out_item_t apply_acl_op(acl_pkg::in_item_t it);
    acl_pkg::out_item_t res;
    logic [7:0]         o1;
    logic [7:0]         o2;
    bit                 ok;
    bit                 done;
    res  = '0;
    ok   = 1'b0;
    done = 1'b0;
    o1   = it.address[31:24];
    o2   = it.address[23:16];
    case (it.operation)
      acl_pkg::OP_CHECK: begin
        case (acl_mode)
          acl_pkg::MODE_LOOPBACK:   ok = (o1 == acl_pkg::OCT_LOOPBACK);
          acl_pkg::MODE_PRIVATE:
            ok = (o1 == acl_pkg::OCT_TEN) ||
                 (o1 == acl_pkg::OCT_192 && o2 == acl_pkg::OCT_168) ||
                 (o1 == acl_pkg::OCT_172 && o2 == acl_pkg::OCT_16);
          acl_pkg::MODE_ALLOW_LIST: ok = table_covers(it.address, 1'b1);
          acl_pkg::MODE_BLOCK_LIST: ok = !table_covers(it.address, 1'b0);
          acl_pkg::MODE_DENY:       ok = 1'b0;
          default:                  ok = 1'b1;   // allow all, spare modes too
        endcase
        chk_total = sat_inc(chk_total);
        if (ok) chk_allowed = sat_inc(chk_allowed);
        else chk_blocked = sat_inc(chk_blocked);
        res.allowed = ok;
      end
      acl_pkg::OP_ADD_ALLOW, acl_pkg::OP_ADD_BLOCK: begin
        // lowest free slot wins, duplicates take a slot of their own
        for (int i = 0; i < acl_pkg::TABLE_DEPTH && !done; i++) begin
          if (!tbl_used[i]) begin
            tbl_addr[i]  = it.address;
            tbl_plen[i]  = it.mask_len;
            tbl_allow[i] = (it.operation == acl_pkg::OP_ADD_ALLOW);
            tbl_used[i]  = 1'b1;
            done         = 1'b1;
          end
        end
        res.status = done ? acl_pkg::STATUS_OK : acl_pkg::STATUS_FULL;
      end
      acl_pkg::OP_REM_ALLOW, acl_pkg::OP_REM_BLOCK: begin
        // exact address compare, prefix ignored, lowest matching slot only
        for (int i = 0; i < acl_pkg::TABLE_DEPTH && !done; i++) begin
          if (tbl_used[i] && tbl_addr[i] == it.address &&
              tbl_allow[i] == (it.operation == acl_pkg::OP_REM_ALLOW)) begin
            tbl_used[i] = 1'b0;
            done        = 1'b1;
          end
        end
        res.status = done ? acl_pkg::STATUS_OK : acl_pkg::STATUS_NOT_FOUND;
      end
      default: ;   // spare operations leave everything as it is
    endcase
    res.total_count   = chk_total;
    res.allowed_count = chk_allowed;
    res.blocked_count = chk_blocked;
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at result %0d: got %h, want %h", what, results_checked, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // rising edge: mirror mode writes, predict accepted input beats, check results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : beat_monitor
    acl_pkg::out_item_t want;
    if (rst_n) begin
      if (cfg_we) acl_mode = cfg_wdata;
      if (in_valid && in_ready) begin
        acl_outcomes.push_back(apply_acl_op(in_data));
        beats_sent++;
      end
      if (out_valid && out_ready) begin
        if (acl_outcomes.size() == 0) begin
          flag_mismatch("unexpected result beat", out_data.total_count, '0);
        end else begin
          want = acl_outcomes.pop_front();
          if (out_data.allowed !== want.allowed)
            flag_mismatch("allowed", out_data.allowed, want.allowed);
          if (out_data.status !== want.status)
            flag_mismatch("status", out_data.status, want.status);
          if (out_data.total_count !== want.total_count)
            flag_mismatch("total_count", out_data.total_count, want.total_count);
          if (out_data.allowed_count !== want.allowed_count)
            flag_mismatch("allowed_count", out_data.allowed_count, want.allowed_count);
          if (out_data.blocked_count !== want.blocked_count)
            flag_mismatch("blocked_count", out_data.blocked_count, want.blocked_count);
          if (want.status == acl_pkg::STATUS_FULL) full_seen++;
          if (want.status == acl_pkg::STATUS_NOT_FOUND) miss_seen++;
        end
        results_checked++;
      end
    end
    in_taken <= rst_n && in_valid && in_ready;
  end

  // ---------------------------------------------------------------------------
  // falling edge: offer the next beat once the last one was taken, and pick
  // the receiver's ready; random gaps unless a steady stretch is running
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : beat_driver
    if (rst_n && (!in_valid || in_taken)) begin
      if (tx_queue.size() != 0 && (tx_steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data  <= tx_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !rx_hold && (tx_steady || $urandom_range(99) >= IDLE_PCT);
  end

  // one long receiver hold-off: the block keeps one result parked, takes one
  // more beat, then has to stall its input while the sender keeps offering
  initial begin : receiver_hold
    wait (pressure_go);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // watchdog, far above the slowest legal run with every beat walking the whole table
  initial begin : watchdog
    #100_000_000;
    $display("cidr_access_list_filter_top verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_op(logic [acl_pkg::OP_W-1:0] op, logic [acl_pkg::ADDR_W-1:0] a,
                         logic [acl_pkg::PLEN_W-1:0] plen);
    acl_pkg::in_item_t it;
    it.operation = op;
    it.address   = a;
    it.mask_len  = plen;
    tx_queue.push_back(it);
  endtask

  // nothing queued, nothing offered, nothing outstanding; ends on a rising edge
  task automatic wait_idle();
    do @(negedge clk);
    while (tx_queue.size() != 0 || in_valid || acl_outcomes.size() != 0);
    @(posedge clk);
  endtask

  task automatic set_mode(logic [acl_pkg::MODE_W-1:0] m);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // mostly well-formed table traffic: adds, removes aimed at earlier adds,
  // checks near stored prefixes or in the well-known ranges, some spare ops
  function automatic acl_pkg::in_item_t random_acl_beat();
    acl_pkg::in_item_t it;
    int                r;
    int                rp;
    r  = $urandom_range(99);
    rp = $urandom_range(99);
    if (rp < 5) it.mask_len = '0;
    else if (rp < 20) it.mask_len = acl_pkg::PLEN_W'($urandom_range(63, 33));
    else if (rp < 30) it.mask_len = acl_pkg::PLEN_W'(32);
    else it.mask_len = acl_pkg::PLEN_W'($urandom_range(31, 1));
    case ($urandom_range(3))
      0: it.address = $urandom;
      1: begin
        case ($urandom_range(3))
          0: it.address = {acl_pkg::OCT_LOOPBACK, 24'($urandom)};
          1: it.address = {acl_pkg::OCT_TEN, 24'($urandom)};
          2: it.address = {acl_pkg::OCT_192,
                           ($urandom_range(1) ? acl_pkg::OCT_168 : 8'($urandom)),
                           16'($urandom)};
          default:
             it.address = {acl_pkg::OCT_172,
                           ($urandom_range(1) ? acl_pkg::OCT_16 : 8'($urandom)),
                           16'($urandom)};
        endcase
      end
      default: begin
        // flip only low bits of a stored address so prefixes decide the match
        if (added_addrs.size() != 0)
          it.address = added_addrs[$urandom_range(added_addrs.size() - 1)] ^
                       ($urandom >> $urandom_range(31, 8));
        else
          it.address = $urandom;
      end
    endcase
    if (r < 40) begin
      it.operation = acl_pkg::OP_CHECK;
    end else if (r < 62) begin
      it.operation = $urandom_range(1) ? acl_pkg::OP_ADD_ALLOW : acl_pkg::OP_ADD_BLOCK;
      added_addrs.push_back(it.address);
      if (added_addrs.size() > 48) void'(added_addrs.pop_front());
    end else if (r < 92) begin
      it.operation = $urandom_range(1) ? acl_pkg::OP_REM_ALLOW : acl_pkg::OP_REM_BLOCK;
      if (added_addrs.size() != 0 && $urandom_range(4) != 0)
        it.address = added_addrs[$urandom_range(added_addrs.size() - 1)];
    end else begin
      it.operation = OP_SPARE_5 + acl_pkg::OP_W'($urandom_range(2));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus: directed corners, random phases over the modes, then a probe tail
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [acl_pkg::MODE_W-1:0] phase_modes [NUM_PHASES];
    logic [acl_pkg::ADDR_W-1:0] probe_addr;
    phase_modes = '{acl_pkg::MODE_ALLOW_LIST, acl_pkg::MODE_BLOCK_LIST,
                    acl_pkg::MODE_PRIVATE, acl_pkg::MODE_NONE,
                    acl_pkg::MODE_LOOPBACK, acl_pkg::MODE_BLOCK_LIST,
                    acl_pkg::MODE_DENY, acl_pkg::MODE_ALLOW_LIST,
                    MODE_SPARE_6};

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // mode after reset allows everything; address extremes, spare ops,
    // removes on an empty table, duplicate adds, zero and oversized prefixes
    push_op(acl_pkg::OP_CHECK, 32'h0000_0000, 6'd0);
    push_op(acl_pkg::OP_CHECK, 32'hFFFF_FFFF, 6'd63);
    push_op(OP_SPARE_5, 32'h1234_5678, 6'd17);
    push_op(OP_SPARE_7, 32'hFFFF_FFFF, 6'd63);
    push_op(acl_pkg::OP_REM_ALLOW, 32'h0102_0304, 6'd0);
    push_op(acl_pkg::OP_REM_BLOCK, 32'h0102_0304, 6'd0);
    push_op(acl_pkg::OP_ADD_ALLOW, 32'hC0A8_0100, 6'd24);
    push_op(acl_pkg::OP_ADD_ALLOW, 32'hC0A8_0100, 6'd24);
    push_op(acl_pkg::OP_ADD_BLOCK, 32'h0A00_0000, 6'd8);
    push_op(acl_pkg::OP_ADD_BLOCK, 32'h0B0B_0B0B, 6'd63);
    push_op(acl_pkg::OP_ADD_ALLOW, 32'hFFFF_FFFF, 6'd32);

    // allow list: hit, miss, and the duplicate still hits after one remove
    set_mode(acl_pkg::MODE_ALLOW_LIST);
    push_op(acl_pkg::OP_CHECK, 32'hC0A8_014D, 6'd0);
    push_op(acl_pkg::OP_CHECK, 32'hC0A8_024D, 6'd0);
    push_op(acl_pkg::OP_REM_ALLOW, 32'hC0A8_0100, 6'd0);
    push_op(acl_pkg::OP_CHECK, 32'hC0A8_014D, 6'd0);

    // block list: /8 block, one past an exact block, then a zero prefix
    // block that catches everything until it is removed again
    set_mode(acl_pkg::MODE_BLOCK_LIST);
    push_op(acl_pkg::OP_CHECK, 32'h0A12_3456, 6'd0);
    push_op(acl_pkg::OP_CHECK, 32'h0B0B_0B0C, 6'd0);
    push_op(acl_pkg::OP_ADD_BLOCK, 32'h0000_0000, 6'd0);
    push_op(acl_pkg::OP_CHECK, 32'h1234_5678, 6'd0);
    push_op(acl_pkg::OP_REM_BLOCK, 32'h0000_0000, 6'd5);

    set_mode(acl_pkg::MODE_LOOPBACK);
    push_op(acl_pkg::OP_CHECK, 32'h7F00_0001, 6'd0);
    push_op(acl_pkg::OP_CHECK, 32'h8000_0000, 6'd0);
    set_mode(acl_pkg::MODE_PRIVATE);
    push_op(acl_pkg::OP_CHECK, 32'hAC10_0001, 6'd0);
    push_op(acl_pkg::OP_CHECK, 32'hC0A9_0000, 6'd0);
    set_mode(acl_pkg::MODE_DENY);
    push_op(acl_pkg::OP_CHECK, 32'h7F00_0001, 6'd0);
    // spare modes behave as allow all
    set_mode(MODE_SPARE_6);
    push_op(acl_pkg::OP_CHECK, 32'h0000_0000, 6'd0);
    set_mode(MODE_SPARE_7);
    push_op(acl_pkg::OP_CHECK, 32'hFFFF_FFFF, 6'd0);

    // random phases; one runs with no gaps on either side, one starts with
    // the long receiver hold-off
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_mode(phase_modes[p]);
      tx_steady = (p == 3);
      if (p == 5) pressure_go = 1'b1;
      repeat (PHASE_ITEMS) tx_queue.push_back(random_acl_beat());
    end
    set_mode(acl_pkg::MODE_BLOCK_LIST);
    tx_steady = 1'b0;

    // one address stored as both kinds, checked under both list modes,
    // then removed twice so the second remove misses
    probe_addr = $urandom;
    push_op(acl_pkg::OP_ADD_ALLOW, probe_addr, 6'd32);
    push_op(acl_pkg::OP_ADD_BLOCK, probe_addr, 6'd32);
    push_op(acl_pkg::OP_CHECK, probe_addr, 6'd0);
    push_op(acl_pkg::OP_CHECK, $urandom, 6'd0);
    set_mode(acl_pkg::MODE_ALLOW_LIST);
    push_op(acl_pkg::OP_CHECK, probe_addr, 6'd0);
    push_op(acl_pkg::OP_REM_ALLOW, probe_addr, 6'd0);
    push_op(acl_pkg::OP_CHECK, probe_addr, 6'd0);
    push_op(acl_pkg::OP_REM_ALLOW, probe_addr, 6'd0);
    push_op(acl_pkg::OP_ADD_ALLOW, $urandom, 6'd8);

    // drain, then give a late or stray result a full table walk to show up
    wait_idle();
    repeat (acl_pkg::TABLE_DEPTH + 64) @(posedge clk);
    if (acl_outcomes.size() != 0)
      flag_mismatch("results never delivered", acl_outcomes.size(), '0);

    $display("run covered %0d input beats and %0d result beats over all eight mode values",
             beats_sent, results_checked);
    $display("table ops: %0d full statuses, %0d remove misses", full_seen, miss_seen);
    if (err_count == 0) begin
      $display("cidr_access_list_filter_top verification clean");
    end else begin
      $display("cidr_access_list_filter_top verification failed");
    end
    $finish;
  end

endmodule

[cidr_access_list_filter_top.f]
design/acl_pkg.sv
design/acl_ram.sv
design/acl_scan.sv
design/cidr_access_list_filter_top.sv
dv/tb_cidr_access_list_filter_top.sv
